/* hdl/bstloc_pkg.sv */
// Shared types and constants for the level-order BST checker.
`default_nettype none
package bstloc_pkg;
	localparam int QUEUE_DEPTH = 1024;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic signed [31:0] val;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef enum logic [1:0] {
		PUSH_ROOT,
		PUSH_LEFT,
		PUSH_RIGHT
	} push_sel_t;

	typedef struct packed {
		logic      load;
		logic      pop;
		logic      push;
		push_sel_t sel;
		logic      clear;
	} dp_cmd_t;

	typedef struct packed {
		logic left_ok;
		logic right_ok;
		logic empty;
		logic full;
	} dp_status_t;
endpackage
`default_nettype wire

/* hdl/bst_level_order_checker_top.sv */
// Top level of the level-order BST checker: controller plus datapath.
// A root, an item of a rejected sequence or one that finds the queue empty passes through
// ST_EVAL and ST_DONE; one that the first parent tried takes passes through ST_EVAL,
// ST_CHECK and ST_DONE, and every parent tried and dropped adds an ST_EVAL and ST_CHECK.
// ST_DONE registers the result and raises in_ready with out_valid. One item at a time;
// a result held in the output register stalls the controller until taken.
// Reset (arst_n low, asynchronous) empties the node queue without clearing its memory.
`default_nettype none
module bst_level_order_checker_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] value,
	input  wire logic               last,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    placed,
	output logic                    sequence_ok,
	output logic                    overflow,
	output logic                    end_of_sequence
);
	import bstloc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	bstloc_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.placed         (placed),
		.sequence_ok    (sequence_ok),
		.overflow       (overflow),
		.end_of_sequence(end_of_sequence),
		.cmd            (cmd),
		.status         (status)
	);

	bstloc_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.value (value),
		.cmd   (cmd),
		.status(status)
	);
endmodule
`default_nettype wire

/* hdl/bstloc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bstloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

/* hdl/bstloc_dp.sv */
// Datapath: node queue, current parent node and the bound comparisons.
`default_nettype none
module bstloc_dp (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic signed [31:0]      value,
	input  wire bstloc_pkg::dp_cmd_t     cmd,
	output bstloc_pkg::dp_status_t       status
);
	import bstloc_pkg::*;

	logic signed [31:0]  value_q;
	node_t               parent_q;
	logic                fresh_q;
	logic [QUEUE_AW-1:0] head_q;
	logic [QUEUE_AW-1:0] tail_q;
	logic [QUEUE_CW-1:0] count_q;
	logic [NODE_W-1:0]   rd_data;
	node_t               parent;
	node_t               push_node;
	logic                do_write;
	logic                do_pop;

	assign parent = fresh_q ? node_t'(rd_data) : parent_q;

	always_comb begin
		case (cmd.sel)
			PUSH_ROOT:  push_node = '{val: value_q, lo: INT_MIN, hi: INT_MAX};
			PUSH_LEFT:  push_node = '{val: value_q, lo: parent.lo, hi: parent.val};
			PUSH_RIGHT: push_node = '{val: value_q, lo: parent.val, hi: parent.hi};
			default:    push_node = '{val: value_q, lo: INT_MIN, hi: INT_MAX};
		endcase
	end

	assign status.empty    = (count_q == '0);
	assign status.full     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign status.left_ok  = (value_q < parent.val) && (value_q > parent.lo);
	assign status.right_ok = (value_q > parent.val) && (value_q < parent.hi);

	assign do_write = cmd.push && !status.full;
	assign do_pop   = cmd.pop && !status.empty;

	bstloc_ram #(
		.WIDTH(NODE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk  (clk),
		.we   (do_write),
		.waddr(tail_q),
		.wdata(push_node),
		.re   (do_pop),
		.raddr(head_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
		end
		if (fresh_q) begin
			parent_q <= node_t'(rd_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			fresh_q <= do_pop;
			if (cmd.clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else begin
				if (do_pop) begin
					head_q  <= (head_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
				if (do_write) begin
					tail_q  <= (tail_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("Empty queue with unequal pointers.");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("Node queue count above its depth.");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (count_q == '0))
		else $error("Node queue not empty after a clear.");
endmodule
`default_nettype wire

/* hdl/bstloc_ctrl.sv */
// Controller: sequence state machine, result register and output handshake.
`default_nettype none
module bstloc_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   last,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        placed,
	output logic                        sequence_ok,
	output logic                        overflow,
	output logic                        end_of_sequence,
	output bstloc_pkg::dp_cmd_t         cmd,
	input  wire bstloc_pkg::dp_status_t status
);
	import bstloc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CHECK,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   parent_valid_q;
	logic   right_next_q;
	logic   expect_root_q;
	logic   ok_q;
	logic   ovf_q;
	logic   last_q;
	logic   res_placed_q;
	logic   out_valid_q;
	logic   placed_q;
	logic   seq_ok_q;
	logic   out_ovf_q;
	logic   eos_q;
	logic   left_take;
	logic   right_take;
	logic   slot_free;

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign placed          = placed_q;
	assign sequence_ok     = seq_ok_q;
	assign overflow        = out_ovf_q;
	assign end_of_sequence = eos_q;

	assign left_take  = !right_next_q && status.left_ok;
	assign right_take = !left_take && status.right_ok;
	assign slot_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		cmd.sel   = PUSH_ROOT;
		cmd.load  = in_valid && in_ready;
		case (state_q)
			ST_EVAL: begin
				if (ok_q && expect_root_q) begin
					cmd.push = 1'b1;
				end else if (ok_q && !parent_valid_q && !status.empty) begin
					cmd.pop = 1'b1;
				end
			end
			ST_CHECK: begin
				cmd.push = left_take || right_take;
				cmd.sel  = left_take ? PUSH_LEFT : PUSH_RIGHT;
			end
			ST_DONE: begin
				cmd.clear = slot_free && last_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			parent_valid_q <= 1'b0;
			right_next_q   <= 1'b0;
			expect_root_q  <= 1'b1;
			ok_q           <= 1'b1;
			ovf_q          <= 1'b0;
			last_q         <= 1'b0;
			res_placed_q   <= 1'b0;
			out_valid_q    <= 1'b0;
			placed_q       <= 1'b0;
			seq_ok_q       <= 1'b0;
			out_ovf_q      <= 1'b0;
			eos_q          <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q  <= last;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (!ok_q) begin
						res_placed_q <= 1'b0;
						state_q      <= ST_DONE;
					end else if (expect_root_q) begin
						expect_root_q <= 1'b0;
						res_placed_q  <= 1'b1;
						if (status.full) begin
							ovf_q <= 1'b1;
							ok_q  <= 1'b0;
						end
						state_q <= ST_DONE;
					end else if (parent_valid_q) begin
						state_q <= ST_CHECK;
					end else if (status.empty) begin
						ok_q         <= 1'b0;
						res_placed_q <= 1'b0;
						state_q      <= ST_DONE;
					end else begin
						parent_valid_q <= 1'b1;
						right_next_q   <= 1'b0;
						state_q        <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					right_next_q <= 1'b1;
					if (!left_take) begin
						parent_valid_q <= 1'b0;
					end
					if (left_take || right_take) begin
						res_placed_q <= 1'b1;
						if (status.full) begin
							ovf_q <= 1'b1;
							ok_q  <= 1'b0;
						end
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_EVAL;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						placed_q    <= res_placed_q;
						seq_ok_q    <= ok_q;
						out_ovf_q   <= ovf_q;
						eos_q       <= last_q;
						if (last_q) begin
							parent_valid_q <= 1'b0;
							right_next_q   <= 1'b0;
							expect_root_q  <= 1'b1;
							ok_q           <= 1'b1;
							ovf_q          <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !status.empty)
		else $error("Pop issued on an empty node queue.");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.pop && cmd.push))
		else $error("Push and pop issued in the same cycle.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && placed_q && !seq_ok_q) |-> out_ovf_q)
		else $error("Placed item rejected without overflow.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ovf_q) |-> !seq_ok_q)
		else $error("Overflow reported with a good sequence.");
endmodule
`default_nettype wire
